>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define MRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define MRQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mrq_pkg.sv
package mrq_pkg;

    // sizing
    localparam int QUEUE_DEPTH  = 32;
    localparam int MAX_READERS  = 8;
    localparam int RESULT_LIMIT = 32;

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int RID_W    = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RCNT_W   = $clog2(MAX_READERS + 1);
    localparam int DRAIN_CAP = (RESULT_LIMIT < QUEUE_DEPTH) ? RESULT_LIMIT : QUEUE_DEPTH;

    // field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int SEQ_W    = 32;
    localparam int RID_IN_W = 3;
    localparam int STATUS_W = 2;
    localparam int NR_W     = 3;
    localparam int CMP_W    = (RCNT_W > RID_IN_W) ? RCNT_W : RID_IN_W + 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_EMIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd2;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // one result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has_event;
        logic [WORD_W-1:0]   out_event;
        logic [SEQ_W-1:0]    out_sequence;
        logic [NR_W-1:0]     new_reader;
        logic                is_last;
    } result_t;

endpackage

>>> src/multi_reader_event_queue.sv
// channel | handshake            | fields
// req     | req_valid, req_stall | opcode, event_word, reader_id
// rsp     | rsp_valid, rsp_stall | status, has_event, out_event, out_sequence,
//         |                      | new_reader, is_last
//
// emit, add consumer and compact with no reader are answered from the idle state.
// drain first reads the reader mark, computes the unseen count and issues the
// first event read, then delivers the events one per transaction from the event memory.
// compact with r readers scans the reader marks, one reader mark read per cycle.
// reset clears counters and sequence state; memories need no clearing pass.
// a stalled rsp holds results in a two-entry output queue; a new request is
// taken while one result still waits there.
module multi_reader_event_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [mrq_pkg::OP_W-1:0]       opcode,
    input  logic [mrq_pkg::WORD_W-1:0]     event_word,
    input  logic [mrq_pkg::RID_IN_W-1:0]   reader_id,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [mrq_pkg::STATUS_W-1:0]   status,
    output logic                           has_event,
    output logic [mrq_pkg::WORD_W-1:0]     out_event,
    output logic [mrq_pkg::SEQ_W-1:0]      out_sequence,
    output logic [mrq_pkg::NR_W-1:0]       new_reader,
    output logic                           is_last
);
    import mrq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DSEEN = 6'b000010,
        ST_DPLAN = 6'b000100,
        ST_DRUN  = 6'b001000,
        ST_CSCAN = 6'b010000,
        ST_CDONE = 6'b100000
    } state_t;

    // circular add on a memory address
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // events a reader has not seen, bounded by the stored count
    function automatic logic [CNT_W-1:0] unseen_of(input logic [SEQ_W-1:0] next_seq,
                                                   input logic [SEQ_W-1:0] seen,
                                                   input logic [CNT_W-1:0] n);
        logic [SEQ_W-1:0] lag;
        lag = next_seq - SEQ_W'(1) - seen;
        if (lag > SEQ_W'(n))
        begin
            return n;
        end
        return lag[CNT_W-1:0];
    endfunction

    function automatic result_t mk_result(input logic [STATUS_W-1:0] st,
                                          input logic has,
                                          input logic [WORD_W-1:0] ev,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [NR_W-1:0] nr,
                                          input logic last);
        result_t r;
        r.status       = st;
        r.has_event    = has;
        r.out_event    = ev;
        r.out_sequence = seq;
        r.new_reader   = nr;
        r.is_last      = last;
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [1:0]         fcount_reg, fcount_next;
    result_t            ent0_reg, ent0_next;
    result_t            ent1_reg, ent1_next;

    logic [SEQ_W-1:0]   oldest_reg, oldest_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RCNT_W-1:0]  rcount_reg, rcount_next;

    logic [RID_W-1:0]   rid_reg, rid_next;
    logic [SEQ_W-1:0]   seen_val_reg, seen_val_next;
    logic [CNT_W-1:0]   unseen_reg, unseen_next;
    logic [CNT_W-1:0]   take_reg, take_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [AW-1:0]      phys_reg, phys_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [RID_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   keep_reg, keep_next;

    // memories
    logic [WORD_W-1:0]  ev_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0]  ev_q;
    logic [AW-1:0]      ev_raddr;
    logic               ev_we;
    logic [SEQ_W-1:0]   seen_mem [MAX_READERS];
    logic [SEQ_W-1:0]   seen_q;
    logic [RID_W-1:0]   seen_raddr;
    logic               seen_we;
    logic [RID_W-1:0]   seen_waddr;
    logic [SEQ_W-1:0]   seen_wdata;

    // handshake helpers
    logic               req_fire;
    logic               pop;
    logic               push;
    logic               can_push;
    result_t            push_data;
    logic [CMP_W-1:0]   rid_ext;
    logic [CMP_W-1:0]   rcnt_ext;
    logic [AW-1:0]      phys_inc;
    logic [CNT_W-1:0]   first_idx;
    logic [AW-1:0]      first_phys;
    logic [CNT_W-1:0]   scan_unseen;

    assign rsp_valid    = (fcount_reg != 2'd0);
    assign pop          = rsp_valid && !rsp_stall;
    assign can_push     = (fcount_reg != 2'd2) || pop;
    assign req_stall    = (state_reg != ST_IDLE) || (fcount_reg == 2'd2);
    assign req_fire     = req_valid && !req_stall;

    assign status       = ent0_reg.status;
    assign has_event    = ent0_reg.has_event;
    assign out_event    = ent0_reg.out_event;
    assign out_sequence = ent0_reg.out_sequence;
    assign new_reader   = ent0_reg.new_reader;
    assign is_last      = ent0_reg.is_last;

    assign rid_ext     = CMP_W'(reader_id);
    assign rcnt_ext    = CMP_W'(rcount_reg);
    assign phys_inc    = wrap_add(phys_reg, CNT_W'(1));
    assign first_idx   = count_reg - unseen_reg;
    assign first_phys  = wrap_add(head_reg, first_idx);
    assign scan_unseen = unseen_of(next_seq_reg, seen_q, count_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        oldest_next   = oldest_reg;
        next_seq_next = next_seq_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        rcount_next   = rcount_reg;
        rid_next      = rid_reg;
        seen_val_next = seen_val_reg;
        unseen_next   = unseen_reg;
        take_next     = take_reg;
        left_next     = left_reg;
        phys_next     = phys_reg;
        seq_next      = seq_reg;
        scan_next     = scan_reg;
        keep_next     = keep_reg;
        ev_raddr      = phys_reg;
        ev_we         = 1'b0;
        seen_raddr    = rid_reg;
        seen_we       = 1'b0;
        seen_waddr    = rid_reg;
        seen_wdata    = seen_val_reg;
        push          = 1'b0;
        push_data     = mk_result(STATUS_OK, 1'b0, '0, '0, '0, 1'b1);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (opcode)
                        OP_EMIT:
                        begin
                            push = 1'b1;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                push_data.status = STATUS_FULL;
                            end
                            else
                            begin
                                ev_we         = 1'b1;
                                tail_next     = wrap_add(tail_reg, CNT_W'(1));
                                count_next    = count_reg + CNT_W'(1);
                                next_seq_next = next_seq_reg + SEQ_W'(1);
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (rid_ext < rcnt_ext)
                            begin
                                rid_next   = rid_ext[RID_W-1:0];
                                seen_raddr = rid_ext[RID_W-1:0];
                                state_next = ST_DSEEN;
                            end
                            else
                            begin
                                push             = 1'b1;
                                push_data.status = STATUS_NOT_FOUND;
                            end
                        end
                        OP_ADD:
                        begin
                            push = 1'b1;
                            if (rcount_reg == RCNT_W'(MAX_READERS))
                            begin
                                push_data.status = STATUS_FULL;
                            end
                            else
                            begin
                                seen_we              = 1'b1;
                                seen_waddr           = rcnt_ext[RID_W-1:0];
                                seen_wdata           = next_seq_reg - SEQ_W'(1);
                                rcount_next          = rcount_reg + RCNT_W'(1);
                                push_data.new_reader = rcnt_ext[NR_W-1:0];
                            end
                        end
                        OP_COMPACT:
                        begin
                            if (rcount_reg == '0)
                            begin
                                push        = 1'b1;
                                oldest_next = next_seq_reg;
                                head_next   = tail_reg;
                                count_next  = '0;
                            end
                            else
                            begin
                                seen_raddr = '0;
                                scan_next  = '0;
                                keep_next  = '0;
                                state_next = ST_CSCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // reader mark arrives from memory
            ST_DSEEN:
            begin
                seen_val_next = seen_q;
                unseen_next   = scan_unseen;
                state_next    = ST_DPLAN;
            end

            // nothing new, or start the event reads
            ST_DPLAN:
            begin
                if (unseen_reg == '0)
                begin
                    if (can_push)
                    begin
                        push       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ev_raddr   = first_phys;
                    phys_next  = first_phys;
                    seq_next   = oldest_reg + SEQ_W'(first_idx);
                    take_next  = (unseen_reg > CNT_W'(DRAIN_CAP)) ? CNT_W'(DRAIN_CAP)
                                                                  : unseen_reg;
                    left_next  = (unseen_reg > CNT_W'(DRAIN_CAP)) ? CNT_W'(DRAIN_CAP)
                                                                  : unseen_reg;
                    state_next = ST_DRUN;
                end
            end

            // one event per transaction, re-read the same entry while stalled
            ST_DRUN:
            begin
                push_data = mk_result(STATUS_OK, 1'b1, ev_q, seq_reg, '0,
                                      left_reg == CNT_W'(1));
                if (can_push)
                begin
                    push      = 1'b1;
                    ev_raddr  = phys_inc;
                    phys_next = phys_inc;
                    seq_next  = seq_reg + SEQ_W'(1);
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        seen_we    = 1'b1;
                        seen_waddr = rid_reg;
                        seen_wdata = seen_val_reg + SEQ_W'(take_reg);
                        state_next = ST_IDLE;
                    end
                end
            end

            // largest unseen count over all readers
            ST_CSCAN:
            begin
                seen_raddr = scan_reg + RID_W'(1);
                scan_next  = scan_reg + RID_W'(1);
                if (scan_unseen > keep_reg)
                begin
                    keep_next = scan_unseen;
                end
                if ((CMP_W'(scan_reg) + CMP_W'(1)) == rcnt_ext)
                begin
                    state_next = ST_CDONE;
                end
            end

            // drop everything older than the kept events
            ST_CDONE:
            begin
                if (can_push)
                begin
                    push        = 1'b1;
                    oldest_next = oldest_reg + SEQ_W'(count_reg - keep_reg);
                    head_next   = wrap_add(head_reg, count_reg - keep_reg);
                    count_next  = keep_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-entry output queue
    always_comb
    begin
        fcount_next = fcount_reg;
        ent0_next   = ent0_reg;
        ent1_next   = ent1_reg;
        if (pop && push)
        begin
            if (fcount_reg == 2'd1)
            begin
                ent0_next = push_data;
            end
            else
            begin
                ent0_next = ent1_reg;
                ent1_next = push_data;
            end
        end
        else if (pop)
        begin
            ent0_next   = ent1_reg;
            fcount_next = fcount_reg - 2'd1;
        end
        else if (push)
        begin
            if (fcount_reg == 2'd0)
            begin
                ent0_next = push_data;
            end
            else
            begin
                ent1_next = push_data;
            end
            fcount_next = fcount_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fcount_reg   <= 2'd0;
            oldest_reg   <= SEQ_W'(1);
            next_seq_reg <= SEQ_W'(1);
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            rcount_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fcount_reg   <= fcount_next;
            oldest_reg   <= oldest_next;
            next_seq_reg <= next_seq_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            rcount_reg   <= rcount_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        ent0_reg     <= ent0_next;
        ent1_reg     <= ent1_next;
        rid_reg      <= rid_next;
        seen_val_reg <= seen_val_next;
        unseen_reg   <= unseen_next;
        take_reg     <= take_next;
        left_reg     <= left_next;
        phys_reg     <= phys_next;
        seq_reg      <= seq_next;
        scan_reg     <= scan_next;
        keep_reg     <= keep_next;
    end

    // event memory
    always_ff @(posedge clk)
    begin
        if (ev_we)
        begin
            ev_mem[tail_reg] <= event_word;
        end
        ev_q <= ev_mem[ev_raddr];
    end

    // reader mark memory
    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_q <= seen_mem[seen_raddr];
    end

endmodule

>>> src/mrq_checker.sv
module mrq_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [mrq_pkg::STATUS_W-1:0]   status,
    input  logic                           has_event,
    input  logic [mrq_pkg::NR_W-1:0]       new_reader,
    input  logic                           is_last
);
    import mrq_pkg::*;

`include "assert_macros.svh"

    // a held result stays offered
    `MRQ_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped while stalled")

    // a drained event always reports ok with new_reader zero
    `MRQ_ASSERT(a_event_ok, rsp_valid && has_event |-> status == STATUS_OK && new_reader == '0, "event transaction with bad status or reader id")

    // errors end the run at once and carry no event
    `MRQ_ASSERT(a_error_single, rsp_valid && status != STATUS_OK |-> is_last && !has_event, "error transaction not a single result")

    // no result during reset
    `MRQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp_valid, "rsp valid during reset")

endmodule

bind multi_reader_event_queue mrq_checker u_mrq_checker (.*);

>>> tb/tb_multi_reader_event_queue.sv
`timescale 1ns / 100ps

module tb_multi_reader_event_queue;
    import mrq_pkg::*;

    localparam int ITEM_TARGET  = 460;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 64;
    localparam int REPORT_LIMIT = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [OP_W-1:0]       opcode;
    logic [WORD_W-1:0]     event_word;
    logic [RID_IN_W-1:0]   reader_id;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [STATUS_W-1:0]   status;
    logic                  has_event;
    logic [WORD_W-1:0]     out_event;
    logic [SEQ_W-1:0]      out_sequence;
    logic [NR_W-1:0]       new_reader;
    logic                  is_last;
    result_t               rsp_fields;

    assign rsp_fields = {status, has_event, out_event, out_sequence, new_reader, is_last};

    multi_reader_event_queue dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .event_word   (event_word),
        .reader_id    (reader_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .has_event    (has_event),
        .out_event    (out_event),
        .out_sequence (out_sequence),
        .new_reader   (new_reader),
        .is_last      (is_last)
    );

    // tracks the broadcast queue and holds the results it owes
    class event_queue_tracker;
        logic [WORD_W-1:0] words [QUEUE_DEPTH];
        logic [SEQ_W-1:0]  oldest_seq;
        logic [SEQ_W-1:0]  next_seq;
        logic [SEQ_W-1:0]  seen_mark [MAX_READERS];
        int unsigned       readers;
        result_t           due_results [$];
        int unsigned       failures;
        int unsigned       reported;

        function new();
            oldest_seq = 1;
            next_seq   = 1;
            readers    = 0;
            failures   = 0;
            reported   = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function logic [SEQ_W-1:0] stored();
            logic [SEQ_W-1:0] n;
            n = next_seq - oldest_seq;
            return (n > QUEUE_DEPTH) ? SEQ_W'(QUEUE_DEPTH) : n;
        endfunction

        // events newer than the reader's mark, bounded by what is stored
        function logic [SEQ_W-1:0] unseen(int unsigned r);
            logic [SEQ_W-1:0] d;
            logic [SEQ_W-1:0] n;
            d = (next_seq - 32'd1) - seen_mark[r];
            n = stored();
            return (d > n) ? n : d;
        endfunction

        function void add_result(logic [STATUS_W-1:0] st, logic has, logic [WORD_W-1:0] ev,
                                 logic [SEQ_W-1:0] seq, logic [NR_W-1:0] nr, logic last);
            result_t r;
            r.status       = st;
            r.has_event    = has;
            r.out_event    = ev;
            r.out_sequence = seq;
            r.new_reader   = nr;
            r.is_last      = last;
            due_results = {due_results, r};
        endfunction

        function string describe(result_t r);
            return $sformatf("status=%0d has_event=%0b event=%h seq=%0d new_reader=%0d last=%0b",
                             r.status, r.has_event, r.out_event, r.out_sequence,
                             r.new_reader, r.is_last);
        endfunction

        function void record_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] word,
                                     logic [RID_IN_W-1:0] rid);
            logic [SEQ_W-1:0] n;
            logic [SEQ_W-1:0] d;
            logic [SEQ_W-1:0] first;
            logic [SEQ_W-1:0] keep;
            logic [SEQ_W-1:0] drop;
            logic [SEQ_W-1:0] u;
            int               i;
            int               idx;
            case (op)
                OP_EMIT:
                begin
                    n = stored();
                    if (n >= QUEUE_DEPTH)
                    begin
                        add_result(STATUS_FULL, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        words[n] = word;
                        next_seq = next_seq + 32'd1;
                        add_result(STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
                    end
                end
                OP_DRAIN:
                begin
                    if (rid >= readers)
                    begin
                        add_result(STATUS_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        d = unseen(rid);
                        if (d == 0)
                        begin
                            add_result(STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            if (d > RESULT_LIMIT)
                                d = SEQ_W'(RESULT_LIMIT);
                            first = stored() - unseen(rid);
                            for (i = 0; i < int'(d); i++)
                            begin
                                idx = int'(first) + i;
                                add_result(STATUS_OK, 1'b1, words[idx],
                                           oldest_seq + SEQ_W'(idx), '0, (i + 1 == int'(d)));
                            end
                            seen_mark[rid] = seen_mark[rid] + d;
                        end
                    end
                end
                OP_ADD:
                begin
                    if (readers >= MAX_READERS)
                    begin
                        add_result(STATUS_FULL, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        seen_mark[readers] = next_seq - 32'd1;
                        add_result(STATUS_OK, 1'b0, '0, '0, NR_W'(readers), 1'b1);
                        readers++;
                    end
                end
                OP_COMPACT:
                begin
                    if (readers == 0)
                    begin
                        oldest_seq = next_seq;
                    end
                    else
                    begin
                        // keep what the most lagging reader still has to see
                        n    = stored();
                        keep = '0;
                        for (i = 0; i < int'(readers); i++)
                        begin
                            u = unseen(i);
                            if (u > keep)
                                keep = u;
                        end
                        drop = n - keep;
                        if (drop != 0)
                        begin
                            for (i = 0; i < int'(keep); i++)
                                words[i] = words[i + int'(drop)];
                            oldest_seq = oldest_seq + drop;
                        end
                    end
                    add_result(STATUS_OK, 1'b0, '0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("unexpected result transaction: %s", describe(got));
                end
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.has_event !== want.has_event ||
                got.out_event !== want.out_event || got.out_sequence !== want.out_sequence ||
                got.new_reader !== want.new_reader || got.is_last !== want.is_last)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    event_queue_tracker tracker = new();

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sample both channels between edges, so nothing races the clock
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                tracker.record_request(opcode, event_word, reader_id);
            if (rsp_valid && !rsp_stall)
                tracker.compare_result(rsp_fields);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back up the request side
    initial
    begin
        int unsigned mode;
        int unsigned span;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        repeat (120) @(posedge clk);
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= ~rsp_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // offer one request transaction, in bursts with random gaps between them
    task automatic send_req(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                            input logic [RID_IN_W-1:0] rid);
        int unsigned gap;
        bit          taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_valid  <= 1'b1;
        opcode     <= op;
        event_word <= word;
        reader_id  <= rid;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic run_directed();
        // no readers yet: unknown reader, then compact of an empty store
        send_req(OP_DRAIN, 32'h0, 3'd0);
        send_req(OP_COMPACT, 32'h0, 3'd0);
        // compact with no reader drops everything
        send_req(OP_EMIT, 32'h0000_0000, 3'd0);
        send_req(OP_EMIT, 32'hFFFF_FFFF, 3'd7);
        send_req(OP_COMPACT, 32'h0, 3'd0);
        // a new reader does not hear older events
        send_req(OP_EMIT, 32'h1234_5678, 3'd0);
        send_req(OP_ADD, 32'h0, 3'd0);
        send_req(OP_DRAIN, 32'h0, 3'd0);
        // ordinary drain of two events
        send_req(OP_EMIT, 32'hA5A5_A5A5, 3'd0);
        send_req(OP_EMIT, 32'h5A5A_5A5A, 3'd0);
        send_req(OP_DRAIN, 32'h0, 3'd0);
        send_req(OP_DRAIN, 32'hFFFF_FFFF, 3'd7);
        // two readers at different marks
        send_req(OP_ADD, 32'h0, 3'd0);
        send_req(OP_EMIT, 32'hFFFF_FFFF, 3'd0);
        send_req(OP_COMPACT, 32'h0, 3'd0);
        send_req(OP_DRAIN, 32'h0, 3'd1);
        send_req(OP_COMPACT, 32'h0, 3'd0);
        send_req(OP_DRAIN, 32'h0, 3'd0);
        send_req(OP_COMPACT, 32'h0, 3'd0);
        send_req(OP_DRAIN, 32'h0, 3'd1);
        send_req(OP_EMIT, 32'h0, 3'd7);
        send_req(OP_ADD, 32'hFFFF_FFFF, 3'd5);
    endtask

    task automatic run_random_sequence();
        int unsigned pick;
        int unsigned r;
        logic [RID_IN_W-1:0] rid;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // burst of emits
            repeat ($urandom_range(1, 6))
                send_req(OP_EMIT, rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
        else if (pick < 55)
        begin
            // drain by a registered reader, now and then any id
            if (tracker.readers == 0 || $urandom_range(0, 9) == 0)
                rid = RID_IN_W'($urandom_range(0, 7));
            else
                rid = RID_IN_W'($urandom_range(0, tracker.readers - 1));
            send_req(OP_DRAIN, rand_word(), rid);
        end
        else if (pick < 62)
        begin
            // every reader catches up, then compact
            for (r = 0; r < tracker.readers; r++)
                send_req(OP_DRAIN, rand_word(), RID_IN_W'(r));
            send_req(OP_COMPACT, rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
        else if (pick < 70)
        begin
            send_req(OP_ADD, rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
        else if (pick < 80)
        begin
            send_req(OP_COMPACT, rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
        else if (pick < 82)
        begin
            // flood past the store depth
            repeat ($urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 3))
                send_req(OP_EMIT, rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
        else
        begin
            send_req(OP_W'($urandom_range(0, 3)), rand_word(), RID_IN_W'($urandom_range(0, 7)));
        end
    endtask

    // reset, stimulus and end of run
    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        opcode      = OP_EMIT;
        event_word  = '0;
        reader_id   = '0;
        items_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < ITEM_TARGET)
            run_random_sequence();
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
